### rtl/core/clook_disk_scheduler_defines.svh
// assertion macros used by the cds_checker file
`ifndef CLOOK_DISK_SCHEDULER_DEFINES_SVH
`define CLOOK_DISK_SCHEDULER_DEFINES_SVH

// same-cycle implication on the scheduler clock
`define CDS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cds check failed");

// next-cycle implication on the scheduler clock
`define CDS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cds check failed");

`endif

### rtl/core/cds_pkg.sv
package cds_pkg;

   localparam int MAX_ENTRIES_DEF = 32;
   localparam int CYL_BITS_DEF    = 16;

   typedef enum logic [0:0] {
      ACT_LOAD = 1'b0,
      ACT_RUN  = 1'b1
   } action_type;

   typedef enum logic [0:0] {
      CSR_HEAD = 1'b0,
      CSR_DIR  = 1'b1
   } csr_index_type;

endpackage

### rtl/core/cds_ram.sv
module cds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/core/clook_disk_scheduler.sv
// load: written at once into an empty store, else larger entries shift up one ram entry per cycle
// run: scan for the head slot, then one result per cycle for N results,
//   each result registered from its ram read data; an empty run gives its single result next cycle
// a load or run is taken only while busy is low; results cannot be stalled
// synchronous reset clears entry count, overflow flag, config and control; the request ram
//   is not cleared, entries above the count are never read
module clook_disk_scheduler #(
   parameter int MAX_ENTRIES = cds_pkg::MAX_ENTRIES_DEF,
   parameter int CYL_BITS    = cds_pkg::CYL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  cds_pkg::action_type   req_action,
   input  logic [CYL_BITS-1:0]   req_cylinder,
   output logic                  busy,
   output logic                  rsp_valid,
   output logic                  rsp_move_valid,
   output logic [CYL_BITS-1:0]   rsp_from_cylinder,
   output logic [CYL_BITS-1:0]   rsp_to_cylinder,
   output logic                  rsp_is_jump,
   output logic [CYL_BITS:0]     rsp_total_movement,
   output logic                  rsp_dropped,
   output logic                  rsp_is_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  cds_pkg::csr_index_type csr_index,
   input  logic [CYL_BITS-1:0]   csr_data
);

   import cds_pkg::*;

   localparam int ADDR_W = $clog2(MAX_ENTRIES);
   localparam int TOT_W  = CYL_BITS + 1;
   localparam logic [ADDR_W-1:0] FULL_COUNT = ADDR_W'(MAX_ENTRIES - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_INS0,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;
   logic [CYL_BITS-1:0] cyl_ff, cyl_in;
   logic [ADDR_W-1:0] p_ff, p_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] left_ff, left_in;
   logic [CYL_BITS-1:0] prev_ff, prev_in;
   logic [TOT_W-1:0] acc_ff, acc_in;
   logic [CYL_BITS-1:0] head_ff, head_in;
   logic dir_ff, dir_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_move_valid_ff, rsp_move_valid_in;
   logic [CYL_BITS-1:0] rsp_from_ff, rsp_from_in;
   logic [CYL_BITS-1:0] rsp_to_ff, rsp_to_in;
   logic rsp_jump_ff, rsp_jump_in;
   logic [TOT_W-1:0] rsp_total_ff, rsp_total_in;
   logic rsp_dropped_ff, rsp_dropped_in;
   logic rsp_last_ff, rsp_last_in;

   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CYL_BITS-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [CYL_BITS-1:0] rd_data;

   logic [ADDR_W-1:0] count_m1;
   logic [ADDR_W-1:0] p_m1;
   logic [ADDR_W-1:0] scan_pos;
   logic [ADDR_W-1:0] first_addr;
   logic [ADDR_W-1:0] next_addr;
   logic [CYL_BITS-1:0] move_dist;
   logic jump;
   logic [TOT_W-1:0] acc_next;

   cds_ram #(
      .WIDTH (CYL_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // address walk and move arithmetic
   always_comb begin
      count_m1 = count_ff - 1'b1;
      p_m1     = p_ff - 1'b1;
      scan_pos = (rd_data >= head_ff) ? p_ff : count_ff;
      if (dir_ff) begin
         first_addr = (scan_pos == count_ff) ? '0 : scan_pos;
         next_addr  = (p_ff == count_m1) ? '0 : p_ff + 1'b1;
         move_dist  = rd_data - prev_ff;
         jump       = (p_ff == '0) && (pos_ff != '0);
      end else begin
         first_addr = (scan_pos == '0) ? count_m1 : scan_pos - 1'b1;
         next_addr  = (p_ff == '0) ? count_m1 : p_m1;
         move_dist  = prev_ff - rd_data;
         jump       = (p_ff == count_m1) && (pos_ff != count_ff);
      end
      acc_next = acc_ff + (jump ? '0 : TOT_W'(move_dist));
   end

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      ovf_in            = ovf_ff;
      cyl_in            = cyl_ff;
      p_in              = p_ff;
      pos_in            = pos_ff;
      left_in           = left_ff;
      prev_in           = prev_ff;
      acc_in            = acc_ff;
      head_in           = head_ff;
      dir_in            = dir_ff;
      rsp_valid_in      = 1'b0;
      rsp_move_valid_in = rsp_move_valid_ff;
      rsp_from_in       = rsp_from_ff;
      rsp_to_in         = rsp_to_ff;
      rsp_jump_in       = rsp_jump_ff;
      rsp_total_in      = rsp_total_ff;
      rsp_dropped_in    = rsp_dropped_ff;
      rsp_last_in       = rsp_last_ff;
      wr_en             = 1'b0;
      wr_addr           = p_ff;
      wr_data           = cyl_ff;
      rd_addr           = '0;

      if (csr_valid) begin
         case (csr_index)
            CSR_HEAD: head_in = csr_data;
            CSR_DIR:  dir_in  = csr_data[0];
            default:  ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_action == ACT_LOAD) begin
                  if (count_ff >= FULL_COUNT) begin
                     ovf_in = 1'b1;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = req_cylinder;
                     count_in = count_ff + 1'b1;
                  end else begin
                     cyl_in   = req_cylinder;
                     rd_addr  = count_m1;
                     p_in     = count_ff;
                     state_in = S_INS;
                  end
               end else if (count_ff == '0) begin
                  // empty schedule
                  rsp_valid_in      = 1'b1;
                  rsp_move_valid_in = 1'b0;
                  rsp_from_in       = head_ff;
                  rsp_to_in         = head_ff;
                  rsp_jump_in       = 1'b0;
                  rsp_total_in      = '0;
                  rsp_dropped_in    = ovf_ff;
                  rsp_last_in       = 1'b1;
                  ovf_in            = 1'b0;
               end else begin
                  rd_addr  = '0;
                  p_in     = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_INS: begin
            // rd_data holds entry p-1
            if (rd_data > cyl_ff) begin
               wr_en   = 1'b1;
               wr_addr = p_ff;
               wr_data = rd_data;
               if (p_ff == ADDR_W'(1)) begin
                  state_in = S_INS0;
               end else begin
                  rd_addr = p_m1 - 1'b1;
                  p_in    = p_m1;
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = p_ff;
               count_in = count_ff + 1'b1;
               state_in = S_IDLE;
            end
         end
         S_INS0: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            count_in = count_ff + 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            // head sorts ahead of equal requests
            if ((rd_data >= head_ff) || (p_ff == count_m1)) begin
               pos_in   = scan_pos;
               p_in     = first_addr;
               rd_addr  = first_addr;
               left_in  = count_ff;
               prev_in  = head_ff;
               acc_in   = '0;
               state_in = S_EMIT;
            end else begin
               p_in    = p_ff + 1'b1;
               rd_addr = p_ff + 1'b1;
            end
         end
         S_EMIT: begin
            rsp_valid_in      = 1'b1;
            rsp_move_valid_in = 1'b1;
            rsp_from_in       = prev_ff;
            rsp_to_in         = rd_data;
            rsp_jump_in       = jump;
            rsp_dropped_in    = ovf_ff;
            prev_in           = rd_data;
            acc_in            = acc_next;
            left_in           = left_ff - 1'b1;
            if (left_ff == ADDR_W'(1)) begin
               rsp_last_in  = 1'b1;
               rsp_total_in = acc_next;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end else begin
               rsp_last_in  = 1'b0;
               rsp_total_in = '0;
               p_in         = next_addr;
               rd_addr      = next_addr;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         head_ff      <= '0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         head_ff      <= head_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cyl_ff            <= cyl_in;
      p_ff              <= p_in;
      pos_ff            <= pos_in;
      left_ff           <= left_in;
      prev_ff           <= prev_in;
      acc_ff            <= acc_in;
      rsp_move_valid_ff <= rsp_move_valid_in;
      rsp_from_ff       <= rsp_from_in;
      rsp_to_ff         <= rsp_to_in;
      rsp_jump_ff       <= rsp_jump_in;
      rsp_total_ff      <= rsp_total_in;
      rsp_dropped_ff    <= rsp_dropped_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_move_valid     = rsp_move_valid_ff;
   assign rsp_from_cylinder  = rsp_from_ff;
   assign rsp_to_cylinder    = rsp_to_ff;
   assign rsp_is_jump        = rsp_jump_ff;
   assign rsp_total_movement = rsp_total_ff;
   assign rsp_dropped        = rsp_dropped_ff;
   assign rsp_is_last        = rsp_last_ff;

endmodule

### rtl/core/cds_checker.sv
`include "clook_disk_scheduler_defines.svh"

module cds_checker #(
   parameter int CYL_BITS = cds_pkg::CYL_BITS_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                busy,
   input logic                rsp_valid,
   input logic                rsp_move_valid,
   input logic [CYL_BITS-1:0] rsp_from_cylinder,
   input logic [CYL_BITS-1:0] rsp_to_cylinder,
   input logic                rsp_is_jump,
   input logic [CYL_BITS:0]   rsp_total_movement,
   input logic                rsp_is_last
);

   // a run streams its items without gaps
   `CDS_ASSERT_NEXT(a_run_gapless, rsp_valid && !rsp_is_last, rsp_valid)
   // block stays busy until the last item of a run
   `CDS_ASSERT_NOW(a_busy_mid_run, rsp_valid && !rsp_is_last, busy)
   // total only on the last item
   `CDS_ASSERT_NOW(a_total_on_last, rsp_valid && !rsp_is_last, rsp_total_movement == '0)
   // empty schedule is a single non-moving item
   `CDS_ASSERT_NOW(a_empty_run, rsp_valid && !rsp_move_valid, rsp_is_last && !rsp_is_jump && (rsp_from_cylinder == rsp_to_cylinder))

endmodule

bind clook_disk_scheduler cds_checker #(.CYL_BITS(CYL_BITS)) u_cds_checker (.*);

### tb/clook_disk_scheduler_checker.sv
`timescale 1ns / 1ps

module clook_disk_scheduler_checker #(
   parameter int MAX_ENTRIES = cds_pkg::MAX_ENTRIES_DEF,
   parameter int CYL_BITS    = cds_pkg::CYL_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  cds_pkg::action_type    req_action,
   input  logic [CYL_BITS-1:0]    req_cylinder,
   input  logic                   rsp_valid,
   input  logic                   rsp_move_valid,
   input  logic [CYL_BITS-1:0]    rsp_from_cylinder,
   input  logic [CYL_BITS-1:0]    rsp_to_cylinder,
   input  logic                   rsp_is_jump,
   input  logic [CYL_BITS:0]      rsp_total_movement,
   input  logic                   rsp_dropped,
   input  logic                   rsp_is_last,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  cds_pkg::csr_index_type csr_index,
   input  logic [CYL_BITS-1:0]    csr_data,
   output int                     outstanding,
   output int                     fail_count
);
   import cds_pkg::*;

   localparam int TOT_W = CYL_BITS + 1;

   typedef struct packed {
      logic                move_valid;
      logic [CYL_BITS-1:0] from_cyl;
      logic [CYL_BITS-1:0] to_cyl;
      logic                is_jump;
      logic [CYL_BITS:0]   total;
      logic                dropped;
      logic                is_last;
   } move_type;

   logic [CYL_BITS-1:0] held_requests[$];
   move_type            expected_moves[$];
   logic                refused_load;
   logic [CYL_BITS-1:0] head_reg;
   logic                dir_reg;
   int                  errors = 0;

   function automatic move_type make_move(logic [CYL_BITS-1:0] from_cyl,
                                          logic [CYL_BITS-1:0] to_cyl, logic is_jump);
      move_type m;
      m            = '0;
      m.move_valid = 1'b1;
      m.from_cyl   = from_cyl;
      m.to_cyl     = to_cyl;
      m.is_jump    = is_jump;
      return m;
   endfunction

   // sorted insertion, equal values keep arrival order
   task automatic add_request(logic [CYL_BITS-1:0] cyl);
      int p;
      logic [CYL_BITS-1:0] tmp;
      if (held_requests.size() >= MAX_ENTRIES - 1) begin
         refused_load = 1'b1;
         return;
      end
      held_requests.push_back(cyl);
      for (p = held_requests.size() - 1; p > 0 && held_requests[p-1] > held_requests[p]; p--) begin
         tmp                = held_requests[p-1];
         held_requests[p-1] = held_requests[p];
         held_requests[p]   = tmp;
      end
   endtask

   task automatic run_schedule();
      logic [CYL_BITS-1:0] path[$];
      move_type            run_moves[$];
      move_type            m;
      int                  n, pos, travel, i;
      pos    = 0;
      travel = 0;
      while (pos < held_requests.size() && held_requests[pos] < head_reg) pos++;
      for (i = 0; i < pos; i++) path.push_back(held_requests[i]);
      path.push_back(head_reg);
      for (i = pos; i < held_requests.size(); i++) path.push_back(held_requests[i]);
      n = path.size();
      if (held_requests.size() == 0) begin
         m            = make_move(head_reg, head_reg, 1'b0);
         m.move_valid = 1'b0;
         run_moves.push_back(m);
      end else if (dir_reg == 1'b0) begin
         for (i = pos - 1; i >= 0; i--) run_moves.push_back(make_move(path[i+1], path[i], 1'b0));
         if (pos < n - 1) run_moves.push_back(make_move(path[0], path[n-1], 1'b1));
         for (i = n - 2; i > pos; i--) run_moves.push_back(make_move(path[i+1], path[i], 1'b0));
         travel = path[pos] - path[0];
         if (pos < n - 1) travel += path[n-1] - path[pos+1];
      end else begin
         for (i = pos + 1; i < n; i++) run_moves.push_back(make_move(path[i-1], path[i], 1'b0));
         if (pos > 0) run_moves.push_back(make_move(path[n-1], path[0], 1'b1));
         for (i = 1; i < pos; i++) run_moves.push_back(make_move(path[i-1], path[i], 1'b0));
         travel = path[n-1] - path[pos];
         if (pos > 0) travel += path[pos-1] - path[0];
      end
      foreach (run_moves[k]) begin
         m         = run_moves[k];
         m.dropped = refused_load;
         if (k == run_moves.size() - 1) begin
            m.total   = travel[CYL_BITS:0];
            m.is_last = 1'b1;
         end
         expected_moves.push_back(m);
      end
      held_requests.delete();
      refused_load = 1'b0;
   endtask

   task automatic check_field(string name, logic [CYL_BITS:0] want, logic [CYL_BITS:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      move_type want;
      if (reset) begin
         held_requests.delete();
         expected_moves.delete();
         refused_load = 1'b0;
         head_reg     = '0;
         dir_reg      = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEAD: head_reg = csr_data;
               CSR_DIR:  dir_reg  = csr_data[0];
               default:  ;
            endcase
         end
         if (start && !busy) begin
            if (req_action == ACT_LOAD) add_request(req_cylinder);
            else run_schedule();
         end
         if (rsp_valid) begin
            if (expected_moves.size() == 0) begin
               $error("unexpected result: from %0d to %0d", rsp_from_cylinder, rsp_to_cylinder);
               errors++;
            end else begin
               want = expected_moves.pop_front();
               check_field("move_valid", TOT_W'(want.move_valid), TOT_W'(rsp_move_valid));
               check_field("from_cylinder", TOT_W'(want.from_cyl), TOT_W'(rsp_from_cylinder));
               check_field("to_cylinder", TOT_W'(want.to_cyl), TOT_W'(rsp_to_cylinder));
               check_field("is_jump", TOT_W'(want.is_jump), TOT_W'(rsp_is_jump));
               check_field("total_movement", want.total, rsp_total_movement);
               check_field("dropped", TOT_W'(want.dropped), TOT_W'(rsp_dropped));
               check_field("is_last", TOT_W'(want.is_last), TOT_W'(rsp_is_last));
            end
         end
      end
      outstanding <= expected_moves.size();
      fail_count  <= errors;
   end

endmodule

### tb/clook_disk_scheduler_tb.sv
`timescale 1ns / 1ps

module clook_disk_scheduler_tb;
   import cds_pkg::*;

   localparam int MAX_ENTRIES = cds_pkg::MAX_ENTRIES_DEF;
   localparam int CYL_BITS    = cds_pkg::CYL_BITS_DEF;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                start        = 1'b0;
   action_type          req_action   = ACT_LOAD;
   logic [CYL_BITS-1:0] req_cylinder = '0;
   logic                csr_valid    = 1'b0;
   csr_index_type       csr_index    = CSR_HEAD;
   logic [CYL_BITS-1:0] csr_data     = '0;

   logic                busy;
   logic                rsp_valid;
   logic                rsp_move_valid;
   logic [CYL_BITS-1:0] rsp_from_cylinder;
   logic [CYL_BITS-1:0] rsp_to_cylinder;
   logic                rsp_is_jump;
   logic [CYL_BITS:0]   rsp_total_movement;
   logic                rsp_dropped;
   logic                rsp_is_last;
   logic                csr_ready;
   int                  outstanding;
   int                  fail_count;

   always #5 clock = ~clock;

   clook_disk_scheduler #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .CYL_BITS   (CYL_BITS)
   ) uut (.*);

   clook_disk_scheduler_checker #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .CYL_BITS   (CYL_BITS)
   ) checker_i (.*);

   task automatic send_item(action_type act, logic [CYL_BITS-1:0] cyl, int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      start        <= 1'b1;
      req_action   <= act;
      req_cylinder <= cyl;
      do @(posedge clock); while (busy);
   endtask

   // let every expected result arrive and any request shifting finish
   task automatic finish_phase();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (2 * MAX_ENTRIES + 8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_regs(logic [CYL_BITS-1:0] head, logic dir);
      csr_valid <= 1'b1;
      csr_index <= CSR_HEAD;
      csr_data  <= head;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_DIR;
      csr_data  <= CYL_BITS'(dir);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CYL_BITS-1:0] mix[6];
      logic [CYL_BITS-1:0] heads[4];
      logic                dirs[4];
      int                  idles[4];
      logic [CYL_BITS-1:0] cyl, prev;
      int                  phase_items, loads;

      mix   = '{16'h0000, 16'hffff, 16'h1234, 16'h1234, 16'h8000, 16'h0001};
      heads = '{16'h0000, 16'hffff, CYL_BITS'($urandom), CYL_BITS'($urandom)};
      dirs  = '{1'b1, 1'b0, 1'b0, 1'b1};
      idles = '{0, 53, 0, 11};
      prev  = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty run, then head equal to requests in both directions
      write_regs(16'h1234, 1'b0);
      send_item(ACT_RUN, 16'h5a5a, 0);
      foreach (mix[i]) send_item(ACT_LOAD, mix[i], 0);
      send_item(ACT_RUN, 16'ha5a5, 0);
      finish_phase();
      write_regs(16'h1234, 1'b1);
      foreach (mix[i]) send_item(ACT_LOAD, mix[i], 0);
      send_item(ACT_RUN, 16'hffff, 0);

      // nothing on the far side of the sweep, so no jump
      finish_phase();
      write_regs(16'hffff, 1'b0);
      send_item(ACT_LOAD, 16'd5, 0);
      send_item(ACT_LOAD, 16'd100, 0);
      send_item(ACT_RUN, 16'h0000, 0);
      finish_phase();
      write_regs(16'h0000, 1'b1);
      send_item(ACT_LOAD, 16'd7, 0);
      send_item(ACT_LOAD, 16'd0, 0);
      send_item(ACT_RUN, 16'h0000, 0);

      for (int ph = 0; ph < 4; ph++) begin
         finish_phase();
         write_regs(heads[ph], dirs[ph]);
         phase_items = 0;
         while (phase_items < 20) begin
            if (ph == 1 && phase_items == 0) loads = MAX_ENTRIES + 1;
            else if ($urandom_range(11) == 0) loads = $urandom_range(MAX_ENTRIES + 2, MAX_ENTRIES - 4);
            else loads = $urandom_range(6);
            for (int j = 0; j < loads; j++) begin
               case ($urandom_range(7))
                  0:       cyl = heads[ph];
                  1:       cyl = prev;
                  2:       cyl = '0;
                  3:       cyl = '1;
                  default: cyl = CYL_BITS'($urandom);
               endcase
               send_item(ACT_LOAD, cyl, idles[ph]);
               prev = cyl;
               phase_items++;
            end
            send_item(ACT_RUN, CYL_BITS'($urandom), idles[ph]);
            phase_items++;
         end
      end

      finish_phase();
      if (fail_count == 0) begin
         $display("clook_disk_scheduler regression: pass");
      end else begin
         $display("clook_disk_scheduler regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("clook_disk_scheduler regression: fail");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/cds_pkg.sv
rtl/core/cds_ram.sv
rtl/core/clook_disk_scheduler.sv
rtl/core/cds_checker.sv
tb/clook_disk_scheduler_checker.sv
tb/clook_disk_scheduler_tb.sv
